@@ hw/rtl/olt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olt_pkg
// Shared types and codes for the ordered list table: command and status
// codes, field widths and the per-cell control bundle.
// ----------------------------------------------------------------------------
package olt_pkg;

    // field widths of the request and result ports
    localparam int DATA_W = 32;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;
    localparam int POS_W  = 6;
    localparam int HELD_W = 7;

    // command codes
    localparam logic [CMD_W-1:0] CMD_APPEND   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEL_LAST = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DEL_VAL  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SEARCH   = 2'd3;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

    // control bundle driven into every cell
    typedef struct packed {
        logic load;     // take the appended value
        logic shift;    // take the neighbor's entry
        logic compare;  // capture the match flag
    } cell_ctrl_t;

endpackage

@@ hw/rtl/olt_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olt_cell
// One list slot: holds an entry, compares it with the search key and takes
// its upper neighbor's entry when the list closes a gap.
// ----------------------------------------------------------------------------
module olt_cell
    import olt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cell_ctrl_t        ctrl,
    input  logic              in_list,
    input  logic [DATA_W-1:0] key,
    input  logic [DATA_W-1:0] load_data,
    input  logic [DATA_W-1:0] neighbor_data,
    output logic [DATA_W-1:0] data,
    output logic              hit
);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic              hit_reg;
    logic              hit_next;

    // entry update: append load has priority over gap closing
    always_comb
    begin
        data_next = data_reg;
        if (ctrl.load)
        begin
            data_next = load_data;
        end
        else if (ctrl.shift)
        begin
            data_next = neighbor_data;
        end
    end

    // match flag, only for slots inside the list
    always_comb
    begin
        hit_next = hit_reg;
        if (ctrl.compare)
        begin
            hit_next = in_list && (data_reg == key);
        end
    end

    // payload register, no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    assign data = data_reg;
    assign hit  = hit_reg;

endmodule

@@ hw/rtl/olt_first_hit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olt_first_hit
// Priority pick over the cell match flags: a log-depth prefix OR gives the
// shift mask from the first match upward, and the index of the first match
// is encoded from its one-hot form.
// ----------------------------------------------------------------------------
module olt_first_hit #(
    parameter int DEPTH = 64,
    parameter int IW    = 6
) (
    input  logic [DEPTH-1:0] hits,
    output logic [DEPTH-1:0] from_first,
    output logic             found,
    output logic [IW-1:0]    index
);

    localparam int LVLS = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DEPTH-1:0] pre [0:LVLS];
    logic [DEPTH-1:0] first_oh;

    assign pre[0] = hits;

    // prefix OR, doubling span at each level
    genvar l;
    generate
        for (l = 0; l < LVLS; l++)
        begin : g_lvl
            localparam int SPAN = 1 << l;
            if (SPAN < DEPTH)
            begin : g_or
                assign pre[l+1] = pre[l] | {pre[l][DEPTH-1-SPAN:0], {SPAN{1'b0}}};
            end
            else
            begin : g_pass
                assign pre[l+1] = pre[l];
            end
        end
    endgenerate

    assign from_first = pre[LVLS];
    assign found      = pre[LVLS][DEPTH-1];
    assign first_oh   = hits & ~{pre[LVLS][DEPTH-2:0], 1'b0};

    // one-hot to index encoder
    always_comb
    begin
        index = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            index = index | ({IW{first_oh[i]}} & IW'(i));
        end
    end

endmodule

@@ hw/rtl/ordered_list_table_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_table_unit
// Ordered list of signed 32-bit values kept in a chain of cells: append,
// delete last, delete first matching value and search.
//
//   channel | signals                               | direction
//   --------+---------------------------------------+----------
//   request | in_valid, in_ready, cmd, value        | in
//   result  | out_valid, out_ready, status,         | out
//           | position, entries_held                |
//
// Each request passes through idle, where it is taken, compare, where all
// cells compare in parallel, pick, where the priority pick registers the
// first match and shift mask, and apply, where the cells shift or load and
// the result is registered. The next request is taken once the block
// returns to idle, even while a result waits for out_ready; that request
// then holds in its last step, and the input stalls, until the result
// register is free.
// Reset clears the entry count and the control state; entry contents are
// not reset.
// ----------------------------------------------------------------------------
module ordered_list_table_unit
    import olt_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [CMD_W-1:0]         cmd,
    input  logic signed [DATA_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [STAT_W-1:0]        status,
    output logic [POS_W-1:0]         position,
    output logic [HELD_W-1:0]        entries_held
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_PICK,
        S_APPLY
    } state_t;

    state_t              state_reg;
    logic [CMD_W-1:0]    cmd_reg;
    logic [DATA_W-1:0]   value_reg;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic [DEPTH-1:0]    mask_reg;
    logic                found_reg;
    logic [IW-1:0]       index_reg;
    logic                out_valid_reg;
    logic [STAT_W-1:0]   status_reg;
    logic [POS_W-1:0]    position_reg;
    logic [HELD_W-1:0]   held_reg;

    logic [DEPTH-1:0]    hits;
    logic [DEPTH-1:0]    from_first;
    logic                found;
    logic [IW-1:0]       index;
    logic [DATA_W-1:0]   cell_data [0:DEPTH-1];

    logic                fire;
    logic                is_empty;
    logic                is_full;
    logic                do_append;
    logic                do_delval;
    logic [STAT_W-1:0]   status_next;
    logic [POS_W-1:0]    position_next;
    logic [IW+POS_W-1:0] index_wide;
    logic [CW+HELD_W-1:0] held_wide;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign status       = status_reg;
    assign position     = position_reg;
    assign entries_held = held_reg;

    // apply step runs once the result register can take the result
    assign fire     = (state_reg == S_APPLY) && (!out_valid_reg || out_ready);
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == FULL_CNT);
    assign do_append = fire && (cmd_reg == CMD_APPEND) && !is_full;
    assign do_delval = fire && (cmd_reg == CMD_DEL_VAL) && found_reg;

    // chain of cells, each taking from its upper neighbor
    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            localparam logic [CW-1:0] IDX = CW'(i);
            cell_ctrl_t        ctrl;
            logic [DATA_W-1:0] nb;

            assign ctrl.load    = do_append && (count_reg == IDX);
            assign ctrl.shift   = do_delval && mask_reg[i];
            assign ctrl.compare = (state_reg == S_CMP);

            if (i < DEPTH - 1)
            begin : g_nb
                assign nb = cell_data[i+1];
            end
            else
            begin : g_last
                assign nb = cell_data[i];
            end

            olt_cell u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .ctrl          (ctrl),
                .in_list       (count_reg > IDX),
                .key           (value_reg),
                .load_data     (value_reg),
                .neighbor_data (nb),
                .data          (cell_data[i]),
                .hit           (hits[i])
            );
        end
    endgenerate

    olt_first_hit #(
        .DEPTH (DEPTH),
        .IW    (IW)
    ) u_first_hit (
        .hits       (hits),
        .from_first (from_first),
        .found      (found),
        .index      (index)
    );

    // result and new count for the current command
    assign index_wide = {{POS_W{1'b0}}, index_reg};
    always_comb
    begin
        status_next   = ST_OK;
        position_next = '0;
        count_next    = count_reg;
        case (cmd_reg)
            CMD_APPEND:
            begin
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            CMD_DEL_LAST:
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            CMD_DEL_VAL:
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else if (!found_reg)
                begin
                    status_next = ST_NOTFOUND;
                end
                else
                begin
                    count_next    = count_reg - CW'(1);
                    position_next = index_wide[POS_W-1:0];
                end
            end
            default:
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else if (!found_reg)
                begin
                    status_next = ST_NOTFOUND;
                end
                else
                begin
                    position_next = index_wide[POS_W-1:0];
                end
            end
        endcase
    end

    assign held_wide = {{HELD_W{1'b0}}, count_next};

    // sequencer, list count and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= ST_OK;
            position_reg  <= '0;
            held_reg      <= '0;
        end
        else
        begin
            // result valid: set on apply, dropped once taken
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_CMP;
                    end
                end
                S_CMP:
                begin
                    state_reg <= S_PICK;
                end
                S_PICK:
                begin
                    state_reg <= S_APPLY;
                end
                S_APPLY:
                begin
                    if (fire)
                    begin
                        count_reg    <= count_next;
                        status_reg   <= status_next;
                        position_reg <= position_next;
                        held_reg     <= held_wide[HELD_W-1:0];
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // request capture and pick results
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg   <= cmd;
            value_reg <= value;
        end
        if (state_reg == S_PICK)
        begin
            mask_reg  <= from_first;
            found_reg <= found;
            index_reg <= index;
        end
    end

endmodule

@@ sim/ordered_list_table_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_table_unit_test
// Self-checking bench for the ordered list table. A shadow copy of the list
// is updated on every accepted request and gives the expected status,
// position and entry count, which are compared with each result in order.
// Directed checks cover the empty list, head, tail and duplicate matches and
// a full list. Random traffic follows with grow and shrink swings, sender
// gaps, result stalls and one long result hold-off that backs up the input.
// ----------------------------------------------------------------------------
module ordered_list_table_unit_test;
    import olt_pkg::*;

    localparam int LIST_DEPTH  = 64;
    localparam int RANDOM_REQS = 240;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [POS_W-1:0]  position;
        logic [HELD_W-1:0] held;
    } list_result_t;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_ready;
    logic [CMD_W-1:0]         cmd       = CMD_APPEND;
    logic signed [DATA_W-1:0] value     = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [STAT_W-1:0]        status;
    logic [POS_W-1:0]         position;
    logic [HELD_W-1:0]        entries_held;

    // shadow list and results still owed by the block
    logic [DATA_W-1:0] shadow_vals [LIST_DEPTH];
    int                shadow_len = 0;
    list_result_t      pending_results [$];

    int errors             = 0;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int hold_cycles        = 0;
    bit grow_list          = 1'b1;

    ordered_list_table_unit #(
        .DEPTH(LIST_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .cmd(cmd),
        .value(value),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .position(position),
        .entries_held(entries_held)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #4_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // apply one request to the shadow list and return its result
    function automatic list_result_t apply_request(input logic [CMD_W-1:0] c,
                                                   input logic [DATA_W-1:0] v);
        list_result_t r;
        int           hit;
        r.status   = ST_OK;
        r.position = '0;
        hit        = -1;
        for (int i = 0; i < shadow_len; i++)
        begin
            if (hit < 0 && shadow_vals[i] == v)
                hit = i;
        end
        case (c)
            CMD_APPEND:
            begin
                if (shadow_len >= LIST_DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    shadow_vals[shadow_len] = v;
                    shadow_len++;
                end
            end
            CMD_DEL_LAST:
            begin
                if (shadow_len == 0)
                    r.status = ST_EMPTY;
                else
                    shadow_len--;
            end
            CMD_DEL_VAL:
            begin
                if (shadow_len == 0)
                    r.status = ST_EMPTY;
                else if (hit < 0)
                    r.status = ST_NOTFOUND;
                else
                begin
                    // close the gap left by the removed entry
                    for (int i = hit; i < shadow_len - 1; i++)
                        shadow_vals[i] = shadow_vals[i + 1];
                    shadow_len--;
                    r.position = POS_W'(hit);
                end
            end
            default:
            begin
                if (shadow_len == 0)
                    r.status = ST_EMPTY;
                else if (hit < 0)
                    r.status = ST_NOTFOUND;
                else
                    r.position = POS_W'(hit);
            end
        endcase
        r.held = HELD_W'(shadow_len);
        return r;
    endfunction

    // operand: often a live entry, a few small values for duplicates, extremes
    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(9))
            0, 1, 2:
            begin
                if (shadow_len > 0)
                    return shadow_vals[$urandom_range(shadow_len - 1)];
                return DATA_W'($urandom());
            end
            3, 4:
                return DATA_W'($urandom_range(7)) - DATA_W'(4);
            5:
            begin
                case ($urandom_range(3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default:
                return DATA_W'($urandom());
        endcase
    endfunction

    // command mix swings the list between empty and full
    function automatic logic [CMD_W-1:0] pick_command();
        int roll;
        if (shadow_len == LIST_DEPTH)
            grow_list = 1'b0;
        else if (shadow_len == 0)
            grow_list = 1'b1;
        roll = $urandom_range(99);
        if (roll < (grow_list ? 62 : 15))
            return CMD_APPEND;
        roll = $urandom_range(99);
        if (roll < 34)
            return CMD_DEL_LAST;
        if (roll < 67)
            return CMD_DEL_VAL;
        return CMD_SEARCH;
    endfunction

    // drive one request, hold it until taken, then record what it should give
    task automatic send_request(input logic [CMD_W-1:0] c, input logic [DATA_W-1:0] v);
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct)
            gap++;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        value    <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(apply_request(c, v));
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // result side: random stalls, or a counted hold-off
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_ready <= 1'b0;
            hold_cycles--;
        end
        else
            out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // compare each result with the oldest expectation
    always @(posedge clk)
    begin
        list_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result status %0d position %0d held %0d",
                         $time, status, position, entries_held);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (want.status !== status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, status);
                    errors++;
                end
                if (want.position !== position)
                begin
                    $display("%0t: position expected %0d actual %0d",
                             $time, want.position, position);
                    errors++;
                end
                if (want.held !== entries_held)
                begin
                    $display("%0t: entries_held expected %0d actual %0d",
                             $time, want.held, entries_held);
                    errors++;
                end
            end
        end
    end

    // delete and search commands on an empty list
    task automatic test_empty_list();
        send_request(CMD_DEL_LAST, 32'h0000_0000);
        send_request(CMD_DEL_VAL, 32'h8000_0000);
        send_request(CMD_SEARCH, 32'h7FFF_FFFF);
    endtask

    // extremes, duplicates, head and tail matches, misses, underflow
    task automatic test_small_list();
        send_request(CMD_APPEND, 32'h8000_0000);
        send_request(CMD_APPEND, 32'h7FFF_FFFF);
        send_request(CMD_APPEND, 32'h0000_0000);
        send_request(CMD_APPEND, 32'hFFFF_FFFF);
        send_request(CMD_APPEND, 32'h0000_0005);
        send_request(CMD_APPEND, 32'h0000_0005);
        send_request(CMD_SEARCH, 32'h0000_0005);
        send_request(CMD_SEARCH, 32'h8000_0000);
        send_request(CMD_SEARCH, 32'hFFFF_FFFF);
        send_request(CMD_SEARCH, 32'h0000_0009);
        send_request(CMD_DEL_VAL, 32'h8000_0000);
        send_request(CMD_DEL_VAL, 32'h0000_0005);
        send_request(CMD_DEL_VAL, 32'h0000_0005);
        send_request(CMD_DEL_VAL, 32'h0000_0009);
        repeat (3) send_request(CMD_DEL_LAST, 32'hFFFF_FFFF);
        send_request(CMD_DEL_LAST, 32'h0000_0000);
    endtask

    // fill to capacity, overflow, then hit and remove the last slot
    task automatic test_full_list();
        logic [DATA_W-1:0] last_val;
        while (shadow_len < LIST_DEPTH)
            send_request(CMD_APPEND, DATA_W'($urandom()));
        repeat (3) send_request(CMD_APPEND, DATA_W'($urandom()));
        last_val = shadow_vals[LIST_DEPTH - 1];
        send_request(CMD_SEARCH, last_val);
        send_request(CMD_DEL_VAL, last_val);
        send_request(CMD_APPEND, 32'h7FFF_FFFF);
        send_request(CMD_DEL_VAL, shadow_vals[0]);
    endtask

    task automatic test_random_traffic(input int count);
        logic [CMD_W-1:0] c;
        repeat (count)
        begin
            c = pick_command();
            send_request(c, pick_value());
        end
    endtask

    // long result hold-off while requests keep coming, so the input stalls
    task automatic test_backpressure();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        @(posedge clk);
        hold_cycles = 200;
        test_random_traffic(16);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_list();
        test_small_list();
        test_full_list();
        test_random_traffic(RANDOM_REQS);

        sender_idle_pct = 67;
        test_random_traffic(RANDOM_REQS);

        sender_idle_pct    = 0;
        receiver_stall_pct = 67;
        test_random_traffic(RANDOM_REQS);

        sender_idle_pct    = 30;
        receiver_stall_pct = 30;
        test_random_traffic(RANDOM_REQS);

        test_backpressure();

        @(negedge clk);
        in_valid <= 1'b0;
        wait_drained();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
